/* design/ffa_pkg.sv */
// package for the first fit free list allocator: types, constants and helpers
`default_nettype none
package ffa_pkg;

  localparam int unsigned FreeDepth = 32;
  localparam int unsigned PageDepth = 8;
  localparam int unsigned OfsW = 32;
  localparam int unsigned FIdxW = $clog2(FreeDepth);
  localparam int unsigned FCntW = $clog2(FreeDepth + 1);
  localparam int unsigned PIdxW = $clog2(PageDepth);
  localparam int unsigned PCntW = $clog2(PageDepth + 1);

  typedef logic [OfsW-1:0] ofs_t;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StFreeFull  = 2'd1,
    StPageFull  = 2'd2,
    StExhausted = 2'd3
  } status_e;

  typedef enum logic {
    ModeAlloc = 1'b0,
    ModeFree  = 1'b1
  } mode_e;

  typedef struct packed {
    logic       mode;
    ofs_t       size;
    logic [4:0] align_log2;
    ofs_t       offset;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    ofs_t        block_offset;
    ofs_t        block_size;
    ofs_t        page_offset;
    ofs_t        page_length;
    logic        page_removed;
    logic        page_added;
  } rsp_t;

  typedef enum logic [4:0] {
    SIdle, SAsz, SAScanRd, SAScanChk, SAPgRd, SAPgChk, SAWrite, SANewRd,
    SANewChk, SANewPg, SFChk, SFScanRd, SFScanChk, SFNbrRd, SFNbrChk,
    SFApply, SShiftRd, SShiftWr, SRmPgRd, SRmScanRd, SRmScanChk,
    SRmPgShRd, SRmPgShWr, SOut
  } state_e;

  // align x up to 2^k; the top bit of the result is set when it does not fit
  function automatic logic [OfsW:0] align_up(input ofs_t x, input logic [4:0] k);
    logic [OfsW:0] m;
    logic [OfsW:0] r;
    m = ({{OfsW{1'b0}}, 1'b1} << k) - 1'b1;
    r = ({1'b0, x} + m) & ~m;
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/first_fit_free_list_allocator.sv */
// first fit free list allocator with coalescing over a paged offset space
//
// usage: a request beat on req_* (allocate or free) produces exactly one
// response beat on rsp_*. one request is handled at a time: req_stall_o is
// high from the accepting edge until the response beat has been taken, so
// the next request is accepted at the earliest after that.
// a zero size free goes straight to the response; an allocate aligns the
// size, scans the free entries, then searches the pages for the containing
// page, or makes a new page, and moves entries down when an entry is dropped.
// a free scans the entries, moves entries for an insert or a merge, and for
// each page above page 0 scans the free entries while looking for a wholly
// free page, then moves entries and pages down on removal. the free list
// memory has one read and one write port and is read once per cycle through
// a registered read port, which sets the pace of these steps.
// reset clears the entry counts and the page size log2 register goes to 16; the
// tables need no clearing. config writes are taken only while idle.
// a stalled response holds its payload until taken; no new request is taken
// meanwhile.
`default_nettype none
module first_fit_free_list_allocator (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  output logic                req_stall_o,
  input  wire ffa_pkg::req_t  req_i,
  output logic                rsp_valid_o,
  input  wire logic           rsp_stall_i,
  output ffa_pkg::rsp_t       rsp_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [4:0]     cfg_data_i
);
  import ffa_pkg::*;

  // free list memory: start and length in one word
  logic [2*OfsW-1:0] fmem [FreeDepth];
  logic [2*OfsW-1:0] pmem [PageDepth];
  logic [2*OfsW-1:0] frd_q, prd_q;
  logic              fwe, pwe;
  logic [FIdxW-1:0]  fwa, fra;
  logic [PIdxW-1:0]  pwa, pra;
  logic [2*OfsW-1:0] fwd, pwd;

  always_ff @(posedge clk_i) begin
    if (fwe) fmem[fwa] <= fwd;
    frd_q <= fmem[fra];
  end
  always_ff @(posedge clk_i) begin
    if (pwe) pmem[pwa] <= pwd;
    prd_q <= pmem[pra];
  end

  state_e state_q, state_d;
  logic [FCntW-1:0] fcnt_q, fcnt_d, i_q, i_d, j_q, j_d;
  logic [PCntW-1:0] pcnt_q, pcnt_d, p_q, p_d;
  logic [4:0]  psl_q, psl_d;
  req_t        req_q, req_d;
  rsp_t        rsp_q, rsp_d;
  logic        rv_q, rv_d;
  ofs_t        asz_q, asz_d, s_q, s_d, l_q, l_d, need_q, need_d;
  ofs_t        ls_q, ls_d, ll_q, ll_d, base_q, base_d, plen_q, plen_d;
  logic        left_q, left_d, right_q, right_d;
  ofs_t        po_q, po_d, pl_q, pl_d;
  // shift control: up (insert) or down (drop)
  logic        sup_q, sup_d;
  logic [FCntW-1:0] stop_q, stop_d;
  logic [2*OfsW-1:0] ins_q, ins_d;
  state_e      after_q, after_d;

  logic [OfsW:0] a_r, n_r, e_r;
  ofs_t fs, fl, ps, pl;
  logic [OfsW:0] pend;

  assign fs = frd_q[2*OfsW-1:OfsW];
  assign fl = frd_q[OfsW-1:0];
  assign ps = prd_q[2*OfsW-1:OfsW];
  assign pl = prd_q[OfsW-1:0];

  assign req_stall_o = !(state_q == SIdle) || rv_q;
  assign cfg_ready_o = (state_q == SIdle) && !rv_q;
  assign rsp_valid_o = rv_q;
  assign rsp_o = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      after_q <= SIdle;
      fcnt_q <= '0;
      pcnt_q <= '0;
      psl_q <= 5'd16;
      rv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      after_q <= after_d;
      fcnt_q <= fcnt_d;
      pcnt_q <= pcnt_d;
      psl_q <= psl_d;
      rv_q <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; rsp_q <= rsp_d; i_q <= i_d; j_q <= j_d; p_q <= p_d;
    asz_q <= asz_d; s_q <= s_d; l_q <= l_d; need_q <= need_d;
    ls_q <= ls_d; ll_q <= ll_d; base_q <= base_d; plen_q <= plen_d;
    left_q <= left_d; right_q <= right_d; po_q <= po_d; pl_q <= pl_d;
    sup_q <= sup_d; stop_q <= stop_d; ins_q <= ins_d;
  end

  always_comb begin
    state_d = state_q; after_d = after_q;
    fcnt_d = fcnt_q; pcnt_d = pcnt_q; psl_d = psl_q;
    rv_d = rv_q; req_d = req_q; rsp_d = rsp_q;
    i_d = i_q; j_d = j_q; p_d = p_q; asz_d = asz_q; s_d = s_q; l_d = l_q;
    need_d = need_q; ls_d = ls_q; ll_d = ll_q; base_d = base_q;
    plen_d = plen_q; left_d = left_q; right_d = right_q;
    po_d = po_q; pl_d = pl_q; sup_d = sup_q; stop_d = stop_q; ins_d = ins_q;
    fwe = 1'b0; fwa = '0; fwd = '0; fra = i_q[FIdxW-1:0];
    pwe = 1'b0; pwa = '0; pwd = '0; pra = p_q[PIdxW-1:0];
    a_r = '0; n_r = '0; e_r = '0; pend = '0;

    if (rv_q && !rsp_stall_i) rv_d = 1'b0;

    case (state_q)
      SIdle: begin
        if (cfg_valid_i && cfg_ready_o) psl_d = cfg_data_i;
        if (req_valid_i && !req_stall_o) begin
          req_d = req_i;
          rsp_d = '0;
          i_d = '0;
          p_d = '0;
          state_d = (req_i.mode == ModeAlloc) ? SAsz : SFChk;
        end
      end
      SAsz: begin
        a_r = align_up(req_q.size, req_q.align_log2);
        asz_d = a_r[OfsW-1:0];
        if (a_r[OfsW]) begin
          rsp_d.status = StExhausted; state_d = SOut;
        end else state_d = SAScanRd;
      end
      SAScanRd: begin
        if (i_q == fcnt_q) begin
          if (pcnt_q == PCntW'(PageDepth)) begin
            rsp_d.status = StPageFull; state_d = SOut;
          end else if (pcnt_q == '0) begin
            base_d = '0; state_d = SANewChk;
          end else begin
            p_d = pcnt_q - 1'b1; state_d = SANewRd;
          end
        end else begin
          fra = i_q[FIdxW-1:0]; state_d = SAScanChk;
        end
      end
      SAScanChk: begin
        a_r = align_up(fs, req_q.align_log2);
        n_r = {1'b0, asz_q} + (a_r - {1'b0, fs});
        if (!a_r[OfsW] && !n_r[OfsW] && fl >= n_r[OfsW-1:0]) begin
          s_d = fs; l_d = fl; need_d = n_r[OfsW-1:0];
          if (fl > n_r[OfsW-1:0]) begin
            fwe = 1'b1; fwa = i_q[FIdxW-1:0];
            fwd = {fs + n_r[OfsW-1:0], fl - n_r[OfsW-1:0]};
            p_d = '0; state_d = SAPgRd;
          end else begin
            sup_d = 1'b0; j_d = i_q; after_d = SAPgRd; state_d = SShiftRd;
          end
        end else begin
          i_d = i_q + 1'b1; state_d = SAScanRd;
        end
      end
      SAPgRd: begin
        if (p_q == pcnt_q) begin
          rsp_d.block_offset = s_q; rsp_d.block_size = need_q; state_d = SOut;
        end else begin
          pra = p_q[PIdxW-1:0]; state_d = SAPgChk;
        end
      end
      SAPgChk: begin
        if (ps <= s_q && (s_q - ps) < pl) begin
          rsp_d.block_offset = s_q; rsp_d.block_size = need_q;
          rsp_d.page_offset = ps; rsp_d.page_length = pl; state_d = SOut;
        end else begin
          p_d = p_q + 1'b1; state_d = SAPgRd;
        end
      end
      SANewRd: begin
        pra = p_q[PIdxW-1:0]; state_d = SANewPg;
      end
      SANewPg: begin
        e_r = {1'b0, ps} + {1'b0, pl};
        base_d = e_r[OfsW-1:0];
        if (e_r[OfsW]) begin
          rsp_d.status = StExhausted; state_d = SOut;
        end else state_d = SANewChk;
      end
      SANewChk: begin
        a_r = align_up(base_q, req_q.align_log2);
        n_r = {1'b0, asz_q} + (a_r - {1'b0, base_q});
        e_r = align_up(n_r[OfsW-1:0], psl_q);
        if (a_r[OfsW] || n_r[OfsW] || e_r[OfsW]) begin
          rsp_d.status = StExhausted; state_d = SOut;
        end else begin
          need_d = n_r[OfsW-1:0];
          plen_d = (e_r[OfsW-1:0] == '0) ? (ofs_t'(1) << psl_q) : e_r[OfsW-1:0];
          state_d = SAWrite;
        end
      end
      SAWrite: begin
        pend = {1'b0, base_q} + {1'b0, plen_q};
        if (pend[OfsW]) begin
          rsp_d.status = StExhausted; state_d = SOut;
        end else if (plen_q > need_q && fcnt_q == FCntW'(FreeDepth)) begin
          rsp_d.status = StFreeFull; state_d = SOut;
        end else begin
          pwe = 1'b1; pwa = pcnt_q[PIdxW-1:0]; pwd = {base_q, plen_q};
          pcnt_d = pcnt_q + 1'b1;
          if (plen_q > need_q) begin
            fwe = 1'b1; fwa = fcnt_q[FIdxW-1:0];
            fwd = {base_q + need_q, plen_q - need_q};
            fcnt_d = fcnt_q + 1'b1;
          end
          rsp_d.block_offset = base_q; rsp_d.block_size = need_q;
          rsp_d.page_offset = base_q; rsp_d.page_length = plen_q;
          rsp_d.page_added = 1'b1; state_d = SOut;
        end
      end
      SFChk: begin
        e_r = {1'b0, req_q.offset} + {1'b0, req_q.size};
        if (req_q.size == '0) state_d = SOut;
        else if (e_r[OfsW]) begin
          rsp_d.status = StExhausted; state_d = SOut;
        end else begin
          need_d = e_r[OfsW-1:0]; state_d = SFScanRd;
        end
      end
      SFScanRd: begin
        if (i_q == fcnt_q) begin
          right_d = 1'b0; state_d = SFNbrRd;
        end else begin
          fra = i_q[FIdxW-1:0]; state_d = SFScanChk;
        end
      end
      SFScanChk: begin
        if (fs <= req_q.offset) begin
          ls_d = fs; ll_d = fl; i_d = i_q + 1'b1; state_d = SFScanRd;
        end else begin
          s_d = fs; l_d = fl; right_d = (fs == need_q); state_d = SFNbrChk;
        end
      end
      SFNbrRd: state_d = SFNbrChk;
      SFNbrChk: begin
        e_r = {1'b0, ls_q} + {1'b0, ll_q};
        left_d = (i_q != '0) && (e_r[OfsW-1:0] == req_q.offset) && !e_r[OfsW];
        state_d = SFApply;
      end
      SFApply: begin
        p_d = pcnt_q;
        if (left_q && right_q) begin
          fwe = 1'b1; fwa = FIdxW'(i_q - 1'b1);
          fwd = {ls_q, ll_q + req_q.size + l_q};
          sup_d = 1'b0; j_d = i_q; after_d = SRmPgRd; state_d = SShiftRd;
        end else if (left_q) begin
          fwe = 1'b1; fwa = FIdxW'(i_q - 1'b1);
          fwd = {ls_q, ll_q + req_q.size}; state_d = SRmPgRd;
        end else if (right_q) begin
          fwe = 1'b1; fwa = i_q[FIdxW-1:0];
          fwd = {req_q.offset, l_q + req_q.size}; state_d = SRmPgRd;
        end else if (fcnt_q == FCntW'(FreeDepth)) begin
          rsp_d.status = StFreeFull; state_d = SOut;
        end else begin
          sup_d = 1'b1; j_d = fcnt_q; stop_d = i_q;
          ins_d = {req_q.offset, req_q.size}; after_d = SRmPgRd;
          state_d = SShiftRd;
        end
      end
      // shift one entry per read and write state pair; down: j..fcnt-2 <- j+1, up: from top
      SShiftRd: begin
        if (sup_q) begin
          if (j_q == stop_q) begin
            fwe = 1'b1; fwa = j_q[FIdxW-1:0]; fwd = ins_q;
            fcnt_d = fcnt_q + 1'b1; state_d = after_q;
          end else begin
            fra = FIdxW'(j_q - 1'b1); state_d = SShiftWr;
          end
        end else begin
          if (j_q + 1'b1 >= fcnt_q) begin
            fcnt_d = fcnt_q - 1'b1; state_d = after_q;
          end else begin
            fra = FIdxW'(j_q + 1'b1); state_d = SShiftWr;
          end
        end
      end
      SShiftWr: begin
        fwe = 1'b1; fwa = j_q[FIdxW-1:0]; fwd = frd_q;
        j_d = sup_q ? j_q - 1'b1 : j_q + 1'b1;
        state_d = SShiftRd;
      end
      // page removal: pages from the top down to page 1
      SRmPgRd: begin
        if (p_q <= PCntW'(1)) state_d = SOut;
        else begin
          pra = PIdxW'(p_q - 1'b1); i_d = '0; state_d = SRmScanRd;
        end
      end
      SRmScanRd: begin
        po_d = ps; pl_d = pl;
        if (i_q == fcnt_q) begin
          p_d = p_q - 1'b1; state_d = SRmPgRd;
        end else begin
          fra = i_q[FIdxW-1:0]; state_d = SRmScanChk;
        end
      end
      SRmScanChk: begin
        if (fs == po_q && fl == pl_q) begin
          rsp_d.page_offset = po_q; rsp_d.page_length = pl_q;
          rsp_d.page_removed = 1'b1;
          sup_d = 1'b0; j_d = i_q; p_d = p_q - 1'b1; after_d = SRmPgShRd;
          state_d = SShiftRd;
        end else begin
          i_d = i_q + 1'b1; fra = FIdxW'(i_q + 1'b1);
          if (i_q + 1'b1 == fcnt_q) begin
            p_d = p_q - 1'b1; state_d = SRmPgRd;
          end
        end
      end
      SRmPgShRd: begin
        if (p_q + 1'b1 >= pcnt_q) begin
          pcnt_d = pcnt_q - 1'b1; state_d = SOut;
        end else begin
          pra = PIdxW'(p_q + 1'b1); state_d = SRmPgShWr;
        end
      end
      SRmPgShWr: begin
        pwe = 1'b1; pwa = p_q[PIdxW-1:0]; pwd = prd_q;
        p_d = p_q + 1'b1; state_d = SRmPgShRd;
      end
      SOut: begin
        rv_d = 1'b1; state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

endmodule
`default_nettype wire

/* design/ffa_checker.sv */
// port level checker for the allocator, bound to the top level
`default_nettype none
module ffa_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          req_valid_i,
  input wire logic          req_stall_o,
  input wire logic          rsp_valid_o,
  input wire logic          rsp_stall_i,
  input wire ffa_pkg::rsp_t rsp_o,
  input wire logic          cfg_ready_o
);
  import ffa_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("stalled response changed");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status != StOk |-> rsp_o.block_offset == '0 &&
    rsp_o.page_length == '0 && !rsp_o.page_added && !rsp_o.page_removed)
    else $error("error response carries data");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !(rsp_o.page_added && rsp_o.page_removed))
    else $error("page added and removed together");

  a_take_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && !req_stall_o |=> req_stall_o && !cfg_ready_o)
    else $error("request taken while busy");

endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .req_valid_i(req_valid_i),
  .req_stall_o(req_stall_o), .rsp_valid_o(rsp_valid_o),
  .rsp_stall_i(rsp_stall_i), .rsp_o(rsp_o), .cfg_ready_o(cfg_ready_o)
);
`default_nettype wire
